// ===== design/atan2_pkg.sv =====
package atan2_pkg;

  // Coordinate and angle formats
  localparam int COORD_WIDTH     = 16;
  localparam int ANGLE_FRAC_BITS = 13;
  localparam int ANGLE_W         = ANGLE_FRAC_BITS + 3;

  // Magnitudes reach 2^(COORD_WIDTH-1), the partial remainder twice that
  localparam int MAG_W = COORD_WIDTH;
  localparam int REM_W = COORD_WIDTH + 1;

  // Ratio z is Q1.15; its magnitude reaches 1.0, so one more quotient bit
  localparam int Z_FRAC  = 15;
  localparam int QUO_W   = Z_FRAC + 1;
  localparam int Z_W     = QUO_W + 1;
  localparam int N_CELLS = QUO_W;

  // Q2.30 arithmetic
  localparam int K_W       = 32;
  localparam int C2P_W     = K_W + Z_W;
  localparam int TP_W      = K_W + Z_W;
  localparam int SUM_W     = K_W + 3;
  localparam int SUM_SHIFT = 30 - ANGLE_FRAC_BITS;

  localparam logic signed [K_W-1:0]   K_C1      = 32'sd1044100225;
  localparam logic signed [K_W-1:0]   K_C2      = -32'sd206102542;
  localparam logic signed [SUM_W-1:0] K_PI      = 35'sd3373259520;
  localparam logic signed [SUM_W-1:0] K_HALF_PI = 35'sd1686629760;

  // pi truncated to the output format
  localparam int ANGLE_PI = int'(K_PI >>> SUM_SHIFT);

  // Per-request flags that travel with the division chain
  typedef struct packed {
    logic undef;  // both coordinates zero
    logic swap;   // |x| <= |y|: z = x/y and the angle is folded about pi/2
    logic x_neg;
    logic y_neg;
    logic z_neg;  // sign of the ratio
  } side_t;

endpackage

// ===== design/atan2_div_cell.sv =====
module atan2_div_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  logic [atan2_pkg::REM_W-1:0]  rem_i,
  input  logic [atan2_pkg::MAG_W-1:0]  den_i,
  input  logic [atan2_pkg::QUO_W-1:0]  quo_i,
  input  atan2_pkg::side_t             side_i,
  output logic                         valid_o,
  output logic [atan2_pkg::REM_W-1:0]  rem_o,
  output logic [atan2_pkg::MAG_W-1:0]  den_o,
  output logic [atan2_pkg::QUO_W-1:0]  quo_o,
  output atan2_pkg::side_t             side_o
);
  import atan2_pkg::*;

  logic [REM_W-1:0] den_ext;
  logic [REM_W-1:0] diff;
  logic [REM_W-1:0] kept;
  logic             fits;
  logic             valid_q;
  logic [REM_W-1:0] rem_q;
  logic [MAG_W-1:0] den_q;
  logic [QUO_W-1:0] quo_q;
  side_t            side_q;

  // Compare-subtract one quotient bit, then shift the remainder
  always_comb begin
    den_ext = {1'b0, den_i};
    diff    = rem_i - den_ext;
    fits    = (rem_i >= den_ext);
    kept    = fits ? diff : rem_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= {kept[REM_W-2:0], 1'b0};
      den_q  <= den_i;
      quo_q  <= {quo_i[QUO_W-2:0], fits};
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign den_o   = den_q;
  assign quo_o   = quo_q;
  assign side_o  = side_q;

endmodule

// ===== design/atan2_poly.sv =====
module atan2_poly (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  logic [atan2_pkg::QUO_W-1:0]         quo_i,
  input  atan2_pkg::side_t                    side_i,
  output logic                                valid_o,
  output logic signed [atan2_pkg::ANGLE_W-1:0] angle_o,
  output logic                                undefined_o
);
  import atan2_pkg::*;

  logic [5:0] valid_q;

  // stage 1: signed ratio and its square
  logic [2*QUO_W-1:0]     sqr;
  logic signed [Z_W-1:0]  z_d;
  logic signed [Z_W-1:0]  z1_q;
  logic [QUO_W-1:0]       zsq1_q;
  side_t                  side1_q;

  // stage 2: C2 * z^2
  logic signed [Z_W-1:0]   zsq_s;
  logic signed [C2P_W-1:0] c2p_d;
  logic signed [C2P_W-1:0] c2p2_q;
  logic signed [Z_W-1:0]   z2_q;
  side_t                   side2_q;

  // stage 3: poly = C1 + C2*z^2 / 2^15
  logic signed [C2P_W-1:0] c2p_b;
  logic signed [C2P_W-1:0] c2p_sh;
  logic signed [K_W-1:0]   poly3_q;
  logic signed [Z_W-1:0]   z3_q;
  side_t                   side3_q;

  // stage 4: poly * z
  logic signed [TP_W-1:0] tp_d;
  logic signed [TP_W-1:0] tp4_q;
  side_t                  side4_q;

  // stage 5: quadrant offsets
  logic signed [TP_W-1:0]  tp_b;
  logic signed [TP_W-1:0]  tp_sh;
  logic signed [SUM_W-1:0] term;
  logic signed [SUM_W-1:0] sum_d;
  logic signed [SUM_W-1:0] sum5_q;
  logic                    undef5_q;

  // stage 6: scale to the output format
  logic signed [SUM_W-1:0]   sum_b;
  logic signed [SUM_W-1:0]   sum_sh;
  logic signed [ANGLE_W-1:0] angle6_q;
  logic                      undef6_q;

  always_comb begin
    sqr   = quo_i * quo_i;
    z_d   = side_i.z_neg ? -$signed({1'b0, quo_i}) : $signed({1'b0, quo_i});
    zsq_s = $signed({1'b0, zsq1_q});
    c2p_d = K_C2 * zsq_s;
    // truncate toward zero
    c2p_b  = c2p2_q[C2P_W-1] ? c2p2_q + C2P_W'(2**Z_FRAC - 1) : c2p2_q;
    c2p_sh = c2p_b >>> Z_FRAC;
    tp_d   = poly3_q * z3_q;
    tp_b   = tp4_q[TP_W-1] ? tp4_q + TP_W'(2**Z_FRAC - 1) : tp4_q;
    tp_sh  = tp_b >>> Z_FRAC;
    term   = $signed(tp_sh[SUM_W-1:0]);
    if (side4_q.undef) begin
      sum_d = '0;
    end else if (!side4_q.swap) begin
      sum_d = term;
      if (side4_q.x_neg) begin
        sum_d = side4_q.y_neg ? term - K_PI : term + K_PI;
      end
    end else begin
      sum_d = K_HALF_PI - term;
      if (side4_q.y_neg) begin
        sum_d = K_HALF_PI - term - K_PI;
      end
    end
    sum_b  = sum5_q[SUM_W-1] ? sum5_q + SUM_W'(2**SUM_SHIFT - 1) : sum5_q;
    sum_sh = sum_b >>> SUM_SHIFT;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[4:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      z1_q     <= z_d;
      zsq1_q   <= sqr[Z_FRAC+QUO_W-1:Z_FRAC];
      side1_q  <= side_i;
      c2p2_q   <= c2p_d;
      z2_q     <= z1_q;
      side2_q  <= side1_q;
      poly3_q  <= K_C1 + $signed(c2p_sh[K_W-1:0]);
      z3_q     <= z2_q;
      side3_q  <= side2_q;
      tp4_q    <= tp_d;
      side4_q  <= side3_q;
      sum5_q   <= sum_d;
      undef5_q <= side4_q.undef;
      angle6_q <= sum_sh[ANGLE_W-1:0];
      undef6_q <= undef5_q;
    end
  end

  assign valid_o     = valid_q[5];
  assign angle_o     = angle6_q;
  assign undefined_o = undef6_q;

endmodule

// ===== design/two_argument_arctangent.sv =====
// Two-argument arctangent: angle of the point (y, x) in radians, Q3.13.
//
// Input channel: in_valid_i / in_stall_o carry one request (y_coord_i,
// x_coord_i), taken at a clock edge with in_valid_i high and in_stall_o low.
// Output channel: out_valid_o / out_stall_i carry angle_o and undefined_o.
// undefined_o is set, with angle_o zero, when both coordinates are zero.
//
// A register picks the ratio operands, a chain of 16 divider cells forms
// one bit of the Q1.15 ratio each, and six stages evaluate the
// polynomial, add the quadrant offset and scale the result.
// Throughput is one request per cycle while the receiver does not stall;
// the divider chain and the polynomial stages all move in lockstep.
//
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_stall_o rises in the same cycle; while the output register is
// empty or being taken, requests keep flowing in. Reset clears only the
// valid bits, so the block comes out of reset empty and ready.
module two_argument_arctangent (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        in_valid_i,
  output logic                                        in_stall_o,
  input  logic signed [atan2_pkg::COORD_WIDTH-1:0]    y_coord_i,
  input  logic signed [atan2_pkg::COORD_WIDTH-1:0]    x_coord_i,
  output logic                                        out_valid_o,
  input  logic                                        out_stall_i,
  output logic signed [atan2_pkg::ANGLE_W-1:0]        angle_o,
  output logic                                        undefined_o
);
  import atan2_pkg::*;

  logic en;

  // operand selection
  logic [MAG_W-1:0] ay;
  logic [MAG_W-1:0] ax;
  logic             swap;
  side_t            side_d;
  logic             prep_valid_q;
  logic [MAG_W-1:0] num_q;
  logic [MAG_W-1:0] den_q;
  side_t            prep_side_q;

  // divider chain taps: index 0 feeds the first cell
  logic             c_valid [N_CELLS+1];
  logic [REM_W-1:0] c_rem   [N_CELLS+1];
  logic [MAG_W-1:0] c_den   [N_CELLS+1];
  logic [QUO_W-1:0] c_quo   [N_CELLS+1];
  side_t            c_side  [N_CELLS+1];

  // Advance everything unless a finished result is held by the receiver
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  // Divide the smaller magnitude by the larger so that |z| <= 1
  always_comb begin
    ay            = y_coord_i[COORD_WIDTH-1] ? MAG_W'(-y_coord_i) : MAG_W'(y_coord_i);
    ax            = x_coord_i[COORD_WIDTH-1] ? MAG_W'(-x_coord_i) : MAG_W'(x_coord_i);
    swap          = !(ax > ay);
    side_d.undef  = (x_coord_i == '0) && (y_coord_i == '0);
    side_d.swap   = swap;
    side_d.x_neg  = x_coord_i[COORD_WIDTH-1];
    side_d.y_neg  = y_coord_i[COORD_WIDTH-1];
    side_d.z_neg  = x_coord_i[COORD_WIDTH-1] ^ y_coord_i[COORD_WIDTH-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prep_valid_q <= 1'b0;
    end else if (en) begin
      prep_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      num_q       <= swap ? ax : ay;
      den_q       <= swap ? ay : ax;
      prep_side_q <= side_d;
    end
  end

  assign c_valid[0] = prep_valid_q;
  assign c_rem[0]   = {1'b0, num_q};
  assign c_den[0]   = den_q;
  assign c_quo[0]   = '0;
  assign c_side[0]  = prep_side_q;

  // One quotient bit per cell, most significant first
  for (genvar i = 0; i < N_CELLS; i++) begin : g_cell
    atan2_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (c_valid[i]),
      .rem_i   (c_rem[i]),
      .den_i   (c_den[i]),
      .quo_i   (c_quo[i]),
      .side_i  (c_side[i]),
      .valid_o (c_valid[i+1]),
      .rem_o   (c_rem[i+1]),
      .den_o   (c_den[i+1]),
      .quo_o   (c_quo[i+1]),
      .side_o  (c_side[i+1])
    );
  end

  // The final remainder and divisor are dropped; the polynomial needs only z
  atan2_poly u_poly (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .valid_i     (c_valid[N_CELLS]),
    .quo_i       (c_quo[N_CELLS]),
    .side_i      (c_side[N_CELLS]),
    .valid_o     (out_valid_o),
    .angle_o     (angle_o),
    .undefined_o (undefined_o)
  );

endmodule

// ===== design/atan2_chk.sv =====
module atan2_chk (
  input logic                                     clk_i,
  input logic                                     rst_ni,
  input logic                                     in_valid_i,
  input logic                                     in_stall_o,
  input logic signed [atan2_pkg::COORD_WIDTH-1:0] y_coord_i,
  input logic signed [atan2_pkg::COORD_WIDTH-1:0] x_coord_i,
  input logic                                     out_valid_o,
  input logic                                     out_stall_i,
  input logic signed [atan2_pkg::ANGLE_W-1:0]     angle_o,
  input logic                                     undefined_o
);
  import atan2_pkg::*;

  localparam logic signed [ANGLE_W-1:0] PI_MAX = ANGLE_W'(ANGLE_PI);
  localparam logic signed [ANGLE_W-1:0] PI_MIN = ANGLE_W'(-ANGLE_PI);

  // A held result keeps its value
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(angle_o) && $stable(undefined_o))
    else $error("result changed while stalled");

  // Never push back on the sender while no result is waiting
  a_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output");

  // The origin reads angle zero
  a_undef_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && undefined_o |-> angle_o == '0)
    else $error("undefined result with nonzero angle");

  // Angle stays within minus pi to pi
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (angle_o <= PI_MAX) && (angle_o >= PI_MIN))
    else $error("angle out of range");

  // In and out stall relate only through the held result
  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a held result");

endmodule

bind two_argument_arctangent atan2_chk u_atan2_chk (.*);

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

  import atan2_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int AW = ANGLE_W;

  // Q2.30 constants for the angle predictor, and Q1.15 unity
  localparam longint Q15_ONE    = 32768;
  localparam longint POLY_C1    = 1044100225;
  localparam longint POLY_C2    = -206102542;
  localparam longint PI_Q30     = 64'sd3373259520;
  localparam longint HALF_PI_Q30 = 1686629760;
  localparam int     DOWNSHIFT  = 30 - ANGLE_FRAC_BITS;

  // Pipeline depth of the block, used for the quiet period at the end
  localparam int PIPE_DEPTH = 23;

  // One predicted result, kept with the request that caused it
  typedef struct packed {
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] x;
    logic signed [AW-1:0] angle;
    logic                 undef;
  } angle_due_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic signed [CW-1:0] y_coord  = '0;
  logic signed [CW-1:0] x_coord  = '0;
  logic                 out_valid;
  logic                 out_stall;
  logic signed [AW-1:0] angle;
  logic                 undefined;

  // Receiver stall comes from two sources: per-result gaps and a long hold
  logic rx_gap_stall = 1'b0;
  logic rx_hold      = 1'b0;
  int   rx_gap       = 0;
  int   hold_len     = 0;

  // Idling switches for the sender and the receiver
  bit idle_tx = 1'b1;
  bit idle_rx = 1'b1;

  angle_due_t angle_due_q[$];

  int err_cnt     = 0;
  int sent_cnt    = 0;
  int checked_cnt = 0;
  int undef_cnt   = 0;

  assign out_stall = rx_gap_stall | rx_hold;

  two_argument_arctangent i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .y_coord_i   (y_coord),
    .x_coord_i   (x_coord),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .angle_o     (angle),
    .undefined_o (undefined)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Hard stop for a hung run
  initial begin
    #2_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Angle predictor
  // ---------------------------------------------------------------------

  // (C1 + C2*z^2)*z in Q2.30 for a Q1.15 ratio, each product truncated
  // toward zero
  function automatic longint poly_times_ratio(input longint z);
    longint zsq;
    longint poly;
    zsq  = (z * z) >>> 15;
    poly = POLY_C1 + (POLY_C2 * zsq) / Q15_ONE;
    return (poly * z) / Q15_ONE;
  endfunction

  function automatic angle_due_t predict_angle(input logic signed [CW-1:0] y,
                                               input logic signed [CW-1:0] x);
    angle_due_t due;
    longint     yl;
    longint     xl;
    longint     ay;
    longint     ax;
    longint     z;
    longint     sum;
    longint     ang;
    yl        = y;
    xl        = x;
    ay        = (yl < 0) ? -yl : yl;
    ax        = (xl < 0) ? -xl : xl;
    due.y     = y;
    due.x     = x;
    due.undef = 1'b0;
    if (yl == 0 && xl == 0) begin
      // Origin: angle reads zero and the flag rises
      sum       = 0;
      due.undef = 1'b1;
    end else if (ax > ay) begin
      // Near the x axis: fold by pi into the left half plane
      z   = (yl * Q15_ONE) / xl;
      sum = poly_times_ratio(z);
      if (xl < 0) begin
        sum = sum + ((yl >= 0) ? PI_Q30 : -PI_Q30);
      end
    end else begin
      // Near the y axis, equal magnitudes included: fold about pi/2
      z   = (xl * Q15_ONE) / yl;
      sum = HALF_PI_Q30 - poly_times_ratio(z);
      if (yl < 0) begin
        sum = sum - PI_Q30;
      end
    end
    ang       = sum / (longint'(1) << DOWNSHIFT);
    due.angle = AW'(ang);
    return due;
  endfunction

  // ---------------------------------------------------------------------
  // Mismatch reporting
  // ---------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    err_cnt++;
  endtask

  // ---------------------------------------------------------------------
  // Receiver: per-result gaps, long hold, result checking
  // ---------------------------------------------------------------------

  // Hold off for the drawn number of cycles before taking the next result
  always @(negedge clk_i) begin
    if (rx_gap > 0) begin
      rx_gap_stall = 1'b1;
      rx_gap--;
    end else begin
      rx_gap_stall = 1'b0;
    end
  end

  // Hold the output for a long stretch whenever a test asks for it
  initial begin
    forever begin
      wait (hold_len != 0);
      rx_hold = 1'b1;
      repeat (hold_len) @(negedge clk_i);
      rx_hold  = 1'b0;
      hold_len = 0;
    end
  end

  // Compare every taken result with the oldest prediction
  always @(posedge clk_i) begin : check_result
    angle_due_t due;
    if (rst_ni && out_valid && !out_stall) begin
      if (angle_due_q.size() == 0) begin
        report_mismatch($sformatf("result angle=%0d undefined=%0b with no request pending",
                                  angle, undefined));
      end else begin
        due = angle_due_q.pop_front();
        if (angle !== due.angle) begin
          report_mismatch($sformatf("y=%0d x=%0d: angle %0d, predicted %0d",
                                    due.y, due.x, angle, due.angle));
        end
        if (undefined !== due.undef) begin
          report_mismatch($sformatf("y=%0d x=%0d: undefined %0b, predicted %0b",
                                    due.y, due.x, undefined, due.undef));
        end
        checked_cnt++;
        if (due.undef) begin
          undef_cnt++;
        end
      end
      rx_gap = idle_rx ? $urandom_range(0, 14) : 0;
    end
  end

  // ---------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------

  // Offer one request, starting and ending at a falling edge. Keep valid
  // high into the next request when no gap is drawn.
  task automatic send_request(input logic signed [CW-1:0] y,
                              input logic signed [CW-1:0] x);
    int gap;
    gap = idle_tx ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid = 1'b1;
    y_coord  = y;
    x_coord  = x;
    do begin
      @(posedge clk_i);
    end while (in_stall);
    angle_due_q.push_back(predict_angle(y, x));
    sent_cnt++;
    @(negedge clk_i);
  endtask

  // Drop valid and wait until every predicted result has been taken
  task automatic wait_results();
    in_valid = 1'b0;
    while (angle_due_q.size() != 0) @(negedge clk_i);
  endtask

  function automatic logic signed [CW-1:0] clamp_coord(input int v);
    if (v > 32767) begin
      return CW'(32767);
    end
    if (v < -32768) begin
      return CW'(-32768);
    end
    return CW'(v);
  endfunction

  function automatic logic signed [CW-1:0] edge_coord();
    case ($urandom_range(0, 5))
      0:       return CW'(-32768);
      1:       return CW'(-32767);
      2:       return CW'(-1);
      3:       return CW'(0);
      4:       return CW'(1);
      default: return CW'(32767);
    endcase
  endfunction

  // Draw a coordinate pair: mostly full range, with a share of pairs near
  // the diagonal, on the axes, at the extremes and of very unequal size
  task automatic draw_pair(output logic signed [CW-1:0] y,
                           output logic signed [CW-1:0] x);
    int a;
    int b;
    case ($urandom_range(0, 9))
      4: begin
        y = CW'(int'($urandom_range(0, 16)) - 8);
        x = CW'(int'($urandom_range(0, 16)) - 8);
      end
      5: begin
        a = int'($urandom_range(0, 65535)) - 32768;
        b = ($urandom_range(0, 1) != 0) ? a : -a;
        b = b + int'($urandom_range(0, 4)) - 2;
        y = clamp_coord(a);
        x = clamp_coord(b);
      end
      6: begin
        if ($urandom_range(0, 1) != 0) begin
          y = '0;
          x = CW'($urandom);
        end else begin
          y = CW'($urandom);
          x = '0;
        end
      end
      7: begin
        y = edge_coord();
        x = edge_coord();
      end
      8: begin
        y = CW'(int'($urandom_range(0, 6)) - 3);
        x = CW'($urandom);
      end
      9: begin
        y = CW'($urandom);
        x = CW'(int'($urandom_range(0, 6)) - 3);
      end
      default: begin
        y = CW'($urandom);
        x = CW'($urandom);
      end
    endcase
  endtask

  task automatic send_random(input int count);
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] x;
    repeat (count) begin
      draw_pair(y, x);
      send_request(y, x);
    end
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Origin, axes, extremes, every quadrant and equal magnitudes
  task automatic test_quadrant_corners();
    idle_tx = 1'b1;
    idle_rx = 1'b1;
    send_request(0, 0);
    send_request(0, 32767);
    send_request(0, 1);
    send_request(0, -1);
    send_request(0, -32768);
    send_request(32767, 0);
    send_request(-32768, 0);
    send_request(-1, 0);
    send_request(1, 1);
    send_request(1, -1);
    send_request(-1, 1);
    send_request(-1, -1);
    send_request(5, -5);
    send_request(32767, 32767);
    send_request(-32768, -32768);
    send_request(-32768, 32767);
    send_request(32767, -32768);
    send_request(-32768, -1);
    send_request(1, -32768);
    send_request(-1, -32768);
    send_request(100, -3);
    send_request(-3, 100);
    wait_results();
  endtask

  // Random pairs with gaps on both sides
  task automatic test_random_gaps();
    idle_tx = 1'b1;
    idle_rx = 1'b1;
    send_random(200);
    wait_results();
  endtask

  // Random pairs at full rate with the receiver always ready
  task automatic test_back_to_back();
    idle_tx = 1'b0;
    idle_rx = 1'b0;
    send_random(150);
    wait_results();
  endtask

  // Hold the output long enough that the pipeline fills and stalls input
  task automatic test_output_hold();
    idle_tx  = 1'b0;
    idle_rx  = 1'b1;
    hold_len = 300;
    send_random(80);
    wait_results();
  endtask

  // Send a burst, let the block run empty, then send another
  task automatic test_pause_for_drain();
    idle_tx = 1'b1;
    idle_rx = 1'b1;
    send_random(40);
    wait_results();
    send_random(40);
    wait_results();
  endtask

  initial begin
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_quadrant_corners();
    test_random_gaps();
    test_back_to_back();
    test_output_hold();
    test_pause_for_drain();

    // Watch for stray results after the last one
    repeat (PIPE_DEPTH + 10) @(negedge clk_i);

    $display("tb_top: %0d requests, %0d results checked, %0d at the origin",
             sent_cnt, checked_cnt, undef_cnt);
    $display("tb_top: covered corners, random gaps, full rate, output hold, drain pause");
    if (err_cnt == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
